>>> rtl/dvrt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Distance-vector route table package
// Shared widths, codes and payload layouts for the route table unit.
// ============================================================================
package dvrt_pkg;

    localparam int MAX_ROUTES = 16;
    localparam int ADDR_W     = $clog2(MAX_ROUTES);
    localparam int CNT_W      = $clog2(MAX_ROUTES + 1);

    localparam int NODE_W = 8;
    localparam int COST_W = 16;
    localparam int IDX_W  = 4;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Action codes carried in s_tuser.
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ROUTE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DOWN  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

    // Status codes carried in m_tuser.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MY_ID    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INFINITY = 1'd1;

    localparam logic [COST_W-1:0] INFINITY_RESET = 16'd999;

    // One table entry as stored in the route memory.
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [NODE_W-1:0] gateway;
        logic [NODE_W-1:0] dest;
    } route_entry_t;

    // Input item data, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]        pad;
        logic [IDX_W-1:0]  entry_index;
        logic [NODE_W-1:0] packet_dest;
        logic [COST_W-1:0] cost_to_neighbor;
        logic [NODE_W-1:0] sender;
        logic [COST_W-1:0] link_cost;
        logic [NODE_W-1:0] hop_id;
        logic [NODE_W-1:0] node_id;
    } item_data_t;

    // Result item data, last field in the lowest bits.
    typedef struct packed {
        logic              pad;
        logic [CNT_W-1:0]  route_count;
        logic [COST_W-1:0] entry_cost;
        logic [NODE_W-1:0] entry_gateway;
        logic [NODE_W-1:0] entry_dest;
        logic              packet_changed;
        logic              changed;
    } result_data_t;

    localparam int S_TDATA_W = $bits(item_data_t);
    localparam int M_TDATA_W = $bits(result_data_t);

endpackage

>>> rtl/distance_vector_route_table_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Distance-vector route table unit
// Route table with self entry, neighbor append, advertised route handling
// with split horizon, neighbor-down poisoning and entry readback.
// ============================================================================
// The unit takes one item at a time. Clear, add neighbor, unused actions
// and foreign or ignored routes pass from ST_EXEC to ST_DONE; reads of a
// valid entry pass from ST_READ to ST_DONE, and a read at or beyond
// route_count goes straight to ST_DONE. An advertised route scans the table
// through the single read port of the route memory, one entry per cycle, and
// stops at the first matching destination. A neighbor-down action visits
// every valid entry the same way. The result sits in an output register, so
// a new item is taken as soon as the previous one has been handed to that
// register, even if the consumer has not yet taken it. Configuration writes
// are accepted in every cycle and must only be issued while the unit is idle.
module distance_vector_route_table_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input items.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // node_id, hop_id, link_cost, sender, cost_to_neighbor, packet_dest,
    // entry_index, zero fill (lowest bit first)
    input  logic [dvrt_pkg::S_TDATA_W-1:0]       s_tdata,
    // action
    input  logic [dvrt_pkg::ACT_W-1:0]           s_tuser,
    // last_in_packet
    input  logic                                 s_tlast,
    // Result items.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // changed, packet_changed, entry_dest, entry_gateway, entry_cost,
    // route_count, zero fill (lowest bit first)
    output logic [dvrt_pkg::M_TDATA_W-1:0]       m_tdata,
    // status
    output logic [dvrt_pkg::STAT_W-1:0]          m_tuser,
    // Configuration writes.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dvrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DOWN,
        ST_READ,
        ST_DONE
    } state_t;

    // Route memory: one write port and one registered read port.
    route_entry_t route_mem [MAX_ROUTES];
    route_entry_t rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    route_entry_t        mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    // Control state.
    state_t              state_reg,   state_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic                flag_reg,    flag_next;
    logic [CNT_W-1:0]    issue_reg,   issue_next;
    logic                pend_reg,    pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                m_valid_reg, m_valid_next;
    logic [NODE_W-1:0]   my_id_reg,   my_id_next;
    logic [COST_W-1:0]   inf_reg,     inf_next;

    // Item and result payload.
    item_data_t          item_reg,    item_next;
    logic [ACT_W-1:0]    action_reg,  action_next;
    logic                last_reg,    last_next;
    logic [COST_W:0]     sum_reg,     sum_next;
    logic                chg_reg,     chg_next;
    logic                pchg_reg,    pchg_next;
    logic [STAT_W-1:0]   status_reg,  status_next;
    route_entry_t        res_entry_reg, res_entry_next;
    result_data_t        m_data_reg,  m_data_next;
    logic [STAT_W-1:0]   m_user_reg,  m_user_next;

    item_data_t          s_item;
    logic [COST_W-1:0]   clamped_sum;
    logic [COST_W-1:0]   clamped_link;
    logic                scan_hit;
    logic                route_chg;
    logic                route_done;
    route_entry_t        new_route;

    assign s_item    = item_data_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // The advertised sum is 17 bits; stored costs never exceed infinity.
    assign clamped_sum  = (sum_reg > {1'b0, inf_reg}) ? inf_reg : sum_reg[COST_W-1:0];
    assign clamped_link = (item_reg.link_cost > inf_reg) ? inf_reg : item_reg.link_cost;
    assign scan_hit     = pend_reg && (rd_data_reg.dest == item_reg.node_id);
    assign new_route    = '{cost: clamped_sum, gateway: item_reg.sender,
                            dest: item_reg.node_id};

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        m_valid_next   = m_valid_reg;
        my_id_next     = my_id_reg;
        inf_next       = inf_reg;
        item_next      = item_reg;
        action_next    = action_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        chg_next       = chg_reg;
        pchg_next      = pchg_reg;
        status_next    = status_reg;
        res_entry_next = res_entry_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        route_chg      = 1'b0;
        route_done     = 1'b0;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MY_ID:    my_id_next = cfg_data[NODE_W-1:0];
                CFG_INFINITY: inf_next   = cfg_data;
                default: ;
            endcase
        end

        // The consumer frees the output register.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    item_next      = s_item;
                    action_next    = s_tuser;
                    last_next      = s_tlast;
                    sum_next       = {1'b0, s_item.link_cost} +
                                     {1'b0, s_item.cost_to_neighbor};
                    chg_next       = 1'b0;
                    pchg_next      = flag_reg;
                    status_next    = STAT_OK;
                    res_entry_next = '0;
                    issue_next     = '0;
                    pend_next      = 1'b0;
                    unique case (s_tuser)
                        ACT_ROUTE: begin
                            // Foreign packets and an empty table skip the scan.
                            if (s_item.packet_dest == my_id_reg && count_reg != '0) begin
                                state_next = ST_SCAN;
                            end else begin
                                state_next = ST_EXEC;
                            end
                        end
                        ACT_DOWN: begin
                            state_next = ST_DOWN;
                        end
                        ACT_READ: begin
                            if (CNT_W'(s_item.entry_index) < count_reg) begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(s_item.entry_index);
                                state_next = ST_READ;
                            end else begin
                                status_next = STAT_BAD_READ;
                                state_next  = ST_DONE;
                            end
                        end
                        default: begin
                            state_next = ST_EXEC;
                        end
                    endcase
                end
            end

            ST_EXEC: begin
                unique case (action_reg)
                    ACT_CLEAR: begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = '{cost: '0, gateway: my_id_reg, dest: my_id_reg};
                        count_next = CNT_W'(1);
                        flag_next  = 1'b0;
                        chg_next   = 1'b1;
                        pchg_next  = 1'b0;
                    end
                    ACT_ADD: begin
                        if (count_reg < CNT_W'(MAX_ROUTES)) begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[ADDR_W-1:0];
                            mem_wdata  = '{cost: clamped_link,
                                           gateway: item_reg.node_id,
                                           dest: item_reg.node_id};
                            count_next = count_reg + CNT_W'(1);
                            chg_next   = 1'b1;
                        end else begin
                            status_next = STAT_FULL;
                        end
                    end
                    ACT_ROUTE: begin
                        // Ignored route: it still ends a packet when marked last.
                        route_done = 1'b1;
                    end
                    default: ;
                endcase
                if (action_reg != ACT_ROUTE) begin
                    state_next = ST_DONE;
                end
            end

            ST_SCAN: begin
                if (scan_hit) begin
                    // First entry with this destination. Slot zero is the self
                    // entry, and split horizon drops routes via this router.
                    if (pend_addr_reg != '0 && item_reg.hop_id != my_id_reg) begin
                        if (rd_data_reg.gateway == item_reg.sender) begin
                            // Forced update from the current next hop.
                            if (({1'b0, rd_data_reg.cost} != sum_reg) &&
                                !((rd_data_reg.cost >= inf_reg) &&
                                  (sum_reg >= {1'b0, inf_reg}))) begin
                                route_chg = 1'b1;
                            end
                        end else if ({1'b0, rd_data_reg.cost} > sum_reg) begin
                            route_chg = 1'b1;
                        end
                    end
                    if (route_chg) begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_addr_reg;
                        mem_wdata = new_route;
                    end
                    pend_next  = 1'b0;
                    route_done = 1'b1;
                end else if (issue_reg < count_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = issue_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = issue_reg[ADDR_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end else begin
                    // Unknown destination: append it.
                    pend_next = 1'b0;
                    if (count_reg < CNT_W'(MAX_ROUTES)) begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[ADDR_W-1:0];
                        mem_wdata  = new_route;
                        count_next = count_reg + CNT_W'(1);
                        route_chg  = 1'b1;
                    end else begin
                        status_next = STAT_FULL;
                    end
                    route_done = 1'b1;
                end
            end

            ST_DOWN: begin
                // Reads run one entry ahead of the poison write-back, so the
                // read and write addresses never coincide.
                if (pend_reg) begin
                    if (rd_data_reg.gateway == item_reg.node_id &&
                        rd_data_reg.cost != '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_addr_reg;
                        mem_wdata = '{cost: inf_reg, gateway: rd_data_reg.gateway,
                                      dest: rd_data_reg.dest};
                        if (rd_data_reg.cost != inf_reg) begin
                            chg_next = 1'b1;
                        end
                    end
                end
                if (issue_reg < count_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = issue_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = issue_reg[ADDR_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                end
            end

            ST_READ: begin
                res_entry_next = rd_data_reg;
                state_next     = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{pad: 1'b0,
                                     route_count: count_reg,
                                     entry_cost: res_entry_reg.cost,
                                     entry_gateway: res_entry_reg.gateway,
                                     entry_dest: res_entry_reg.dest,
                                     packet_changed: pchg_reg,
                                     changed: chg_reg};
                    m_user_next  = status_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A route item folds its change into the packet flag; the last
        // route of a packet reports the flag and then clears it.
        if (route_done) begin
            chg_next   = route_chg;
            pchg_next  = flag_reg | route_chg;
            flag_next  = last_reg ? 1'b0 : (flag_reg | route_chg);
            state_next = ST_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            route_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= route_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            flag_reg    <= 1'b0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            my_id_reg   <= '0;
            inf_reg     <= INFINITY_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            flag_reg    <= flag_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            my_id_reg   <= my_id_next;
            inf_reg     <= inf_next;
        end
        pend_addr_reg <= pend_addr_next;
        item_reg      <= item_next;
        action_reg    <= action_next;
        last_reg      <= last_next;
        sum_reg       <= sum_next;
        chg_reg       <= chg_next;
        pchg_reg      <= pchg_next;
        status_reg    <= status_next;
        res_entry_reg <= res_entry_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

endmodule

>>> rtl/dvrt_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Distance-vector route table checker
// Port-level assertions for the route table unit, bound to the top level.
// ============================================================================
module dvrt_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [dvrt_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic [dvrt_pkg::ACT_W-1:0]           s_tuser,
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [dvrt_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic [dvrt_pkg::STAT_W-1:0]          m_tuser,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [dvrt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dvrt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dvrt_pkg::*;

    result_data_t res;
    assign res = result_data_t'(m_tdata);

    // A held result keeps its payload until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One item at a time: the input closes right after a transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // The table never reports more entries than it holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res.route_count <= CNT_W'(MAX_ROUTES))
        else $error("route count beyond table size");

    // A dropped append or a bad read never changes the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_FULL || m_tuser == STAT_BAD_READ) |-> !res.changed)
        else $error("error status with table change");

    // A bad read returns an all-zero entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STAT_BAD_READ |->
            res.entry_dest == '0 && res.entry_gateway == '0 && res.entry_cost == '0)
        else $error("bad read returned entry data");

endmodule

bind distance_vector_route_table_unit dvrt_checker u_dvrt_checker (.*);
